/* rtl/core/arx_plant_model_step_macros.svh */
// Assertion macros for the ARX plant model step block.
`ifndef ARX_PLANT_MODEL_STEP_MACROS_SVH
`define ARX_PLANT_MODEL_STEP_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define ARXPM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ARXPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/arxpm_pkg.sv */
package arxpm_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 16;
   localparam int DT_W       = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int PROD_W     = SAMPLE_W + COEF_W;
   localparam int FRAC_BITS  = 14;
   localparam int ROUND_BIAS = 1 << (FRAC_BITS - 1);

   localparam int NUM_A_DEF     = 3;
   localparam int NUM_B_DEF     = 3;
   localparam int MAX_DELAY_DEF = 8;

   localparam int CSR_NUM_A_REGS = 3;
   localparam int CSR_NUM_B_REGS = 3;

   localparam logic [DT_W-1:0] DEAD_TIME_RST = DT_W'(1);

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_A1   = 3'd0,
      CSR_COEF_A2   = 3'd1,
      CSR_COEF_A3   = 3'd2,
      CSR_COEF_B1   = 3'd3,
      CSR_COEF_B2   = 3'd4,
      CSR_COEF_B3   = 3'd5,
      CSR_DEAD_TIME = 3'd6
   } csr_index_type;

endpackage

/* rtl/core/arx_plant_model_step.sv */
//  channel | ports                                  | direction
//  --------+----------------------------------------+----------
//  req     | req_valid, req_stall, req_sample_in    | in
//  rsp     | rsp_valid, rsp_stall, rsp_sample_out   | out
//  csr     | csr_write_en, csr_index, csr_data      | in
//
//  One word per clock while req_stall is low; a taken sample passes through the input
//  register, then the tap multiply, sum and round into the result register, to reach rsp.
//  The output feedback closes through the result stage.
//  Synchronous reset clears both histories and the coefficients, and sets dead time to 1.
//  req_stall rises only when the input register is full and the result word
//  is held by rsp_stall.

`include "arx_plant_model_step_macros.svh"

module arx_plant_model_step
   import arxpm_pkg::*;
#(
   parameter int NUM_A     = NUM_A_DEF,
   parameter int NUM_B     = NUM_B_DEF,
   parameter int MAX_DELAY = MAX_DELAY_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [SAMPLE_W-1:0]  req_sample_in,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [SAMPLE_W-1:0]  rsp_sample_out,
   input  logic                        csr_write_en,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_data
);

   localparam int HIST_W = NUM_B + MAX_DELAY - 1;
   localparam int ACC_W  = PROD_W + $clog2(NUM_A + NUM_B) + 1;

   logic signed [COEF_W-1:0]   coef_a_ff [NUM_A];
   logic signed [COEF_W-1:0]   coef_b_ff [NUM_B];
   logic [DT_W-1:0]            dead_time_ff;

   logic                       in_valid_ff;
   logic signed [SAMPLE_W-1:0] in_sample_ff;
   logic signed [SAMPLE_W-1:0] in_hist_ff [HIST_W];
   logic signed [SAMPLE_W-1:0] out_hist_ff [NUM_A];

   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff;
   logic signed [SAMPLE_W-1:0] rsp_sample_in;

   logic                       fire;
   logic                       req_take;
   logic signed [SAMPLE_W-1:0] tap_u [NUM_B];
   logic signed [PROD_W-1:0]   prod_b [NUM_B];
   logic signed [PROD_W-1:0]   prod_a [NUM_A];
   logic signed [ACC_W-1:0]    acc;
   logic signed [ACC_W-1:0]    acc_q;
   logic                       fits;

   assign fire      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign req_take  = req_valid && !req_stall;

   // pick the delayed input for each tap; zero and oversize delays are clamped
   always_comb begin
      for (int i = 0; i < NUM_B; i++) begin
         tap_u[i] = '0;
         for (int k = 1; k <= MAX_DELAY; k++) begin
            if ((32'(dead_time_ff) == k) ||
                (k == 1 && dead_time_ff == '0) ||
                (k == MAX_DELAY && 32'(dead_time_ff) > MAX_DELAY)) begin
               tap_u[i] = tap_u[i] | in_hist_ff[k - 1 + i];
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_B; i++) begin
         prod_b[i] = coef_b_ff[i] * tap_u[i];
      end
      for (int i = 0; i < NUM_A; i++) begin
         prod_a[i] = coef_a_ff[i] * out_hist_ff[i];
      end
   end

   always_comb begin
      acc = '0;
      for (int i = 0; i < NUM_B; i++) begin
         acc = acc + ACC_W'(prod_b[i]);
      end
      for (int i = 0; i < NUM_A; i++) begin
         acc = acc - ACC_W'(prod_a[i]);
      end
      acc_q = (acc + ACC_W'(ROUND_BIAS)) >>> FRAC_BITS;
      fits  = (&acc_q[ACC_W-1:SAMPLE_W-1]) || !(|acc_q[ACC_W-1:SAMPLE_W-1]);
      if (fits) begin
         rsp_sample_in = acc_q[SAMPLE_W-1:0];
      end else if (acc_q[ACC_W-1]) begin
         rsp_sample_in = SAMPLE_MIN;
      end else begin
         rsp_sample_in = SAMPLE_MAX;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < NUM_A; j++) begin
            coef_a_ff[j] <= '0;
         end
         for (int j = 0; j < NUM_B; j++) begin
            coef_b_ff[j] <= '0;
         end
         dead_time_ff <= DEAD_TIME_RST;
      end else if (csr_write_en) begin
         for (int j = 0; j < NUM_A; j++) begin
            if (j < CSR_NUM_A_REGS &&
                csr_index == CSR_IDX_W'(32'(CSR_COEF_A1) + j)) begin
               coef_a_ff[j] <= csr_data[COEF_W-1:0];
            end
         end
         for (int j = 0; j < NUM_B; j++) begin
            if (j < CSR_NUM_B_REGS &&
                csr_index == CSR_IDX_W'(32'(CSR_COEF_B1) + j)) begin
               coef_b_ff[j] <= csr_data[COEF_W-1:0];
            end
         end
         if (csr_index == CSR_DEAD_TIME) begin
            dead_time_ff <= csr_data[DT_W-1:0];
         end
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_sample_ff <= req_sample_in;
      end
   end

   // advance both histories with each word that moves to the result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < HIST_W; j++) begin
            in_hist_ff[j] <= '0;
         end
         for (int j = 0; j < NUM_A; j++) begin
            out_hist_ff[j] <= '0;
         end
      end else if (fire) begin
         in_hist_ff[0] <= in_sample_ff;
         for (int j = 1; j < HIST_W; j++) begin
            in_hist_ff[j] <= in_hist_ff[j-1];
         end
         out_hist_ff[0] <= rsp_sample_in;
         for (int j = 1; j < NUM_A; j++) begin
            out_hist_ff[j] <= out_hist_ff[j-1];
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_sample_ff <= rsp_sample_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

   `ARXPM_ASSERT_NEXT(a_fire_loads_rsp, clock, reset, fire, rsp_valid_ff, "result not loaded")
   `ARXPM_ASSERT_NEXT(a_feedback, clock, reset, fire, out_hist_ff[0] == rsp_sample_ff, "bad feedback")
   `ARXPM_ASSERT_SAME(a_stall_full, clock, reset, req_stall, in_valid_ff && rsp_valid_ff && rsp_stall, "bad stall")

endmodule
